// File: rtl/swss_pkg.sv
// Shared constants, types and codes of the sliding window sample statistics block.
// No dependencies; every other RTL file refers to this package by scoped names.
`default_nettype none

package swss_pkg;

    // Store depth is a power of two: 2 ** DEPTH_LOG2 entries (1 to 8 -> 2 to 256)
    localparam int DEPTH_LOG2   = 6;
    localparam int WINDOW_DEPTH = 1 << DEPTH_LOG2;
    localparam int SAMPLE_BITS  = 12;

    // Window length (1 .. WINDOW_DEPTH) and rank counts
    localparam int LEN_BITS  = DEPTH_LOG2 + 1;
    // Step counter (0 .. WINDOW_DEPTH - 1)
    localparam int CNT_BITS  = DEPTH_LOG2;
    // Effective length exponent (0 .. DEPTH_LOG2)
    localparam int LOG2_BITS = $clog2(DEPTH_LOG2 + 1);
    localparam int SUM_BITS  = SAMPLE_BITS + DEPTH_LOG2;

    localparam int MODE_BITS      = 3;
    localparam int CFG_DATA_BITS  = 3;
    localparam int CFG_INDEX_BITS = 1;

    // Statistic selection codes; the remaining codes pass the sample
    localparam logic [MODE_BITS-1:0] MODE_PASS   = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_MEAN   = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_MIN    = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_MAX    = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_MEDIAN = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STAT_MODE   = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_LOG2 = 1'b1;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT,
        CELL_ROTATE,
        CELL_REFILL
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     count_en;
    } cell_ctrl_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] value;
        logic [LEN_BITS-1:0]    lt;
        logic [LEN_BITS-1:0]    le;
    } cell_data_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_FIN
    } seq_state_t;

endpackage

`default_nettype wire

// File: rtl/sliding_window_sample_statistics.sv
// Sliding window sample statistics: a row of window cells and the sequencer driving it.
// Depends on swss_pkg and swss_cell.
// A result is registered once its request has been scanned through the L window cells (and,
// for the median, picked in a second pass), L being the window length, and the output is free;
// no new request is taken before then, the pace being set by the rotation of the cell row.
// Reset (asynchronous, active low) zeroes the window, the last sample and both registers.
`default_nettype none

module sliding_window_sample_statistics (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // Input requests
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic [swss_pkg::SAMPLE_BITS-1:0]      sample,
    // Result requests
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic [swss_pkg::SAMPLE_BITS-1:0]           statistic,
    // Configuration writes
    input  wire logic                                  cfg_we,
    input  wire logic [swss_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [swss_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    // ------------------------------------------------------------------------
    // Operation
    //   On acceptance every window cell takes its right neighbour's sample and
    //   the tail cell (index L - 1) takes the new sample; cells beyond the
    //   window hold. Rank counts are cleared at the same time.
    //   Scan: in each of L steps the window rotates left by one cell, the tail taking
    //   cell 0. Cell 0 is broadcast as a probe: the sequencer folds it into the
    //   sum, minimum and maximum, and every window cell counts probes below and not
    //   above its own sample. Counts travel with their samples, so after L
    //   steps the window is back in age order, each sample with its rank span.
    //   Pick (median only): L more rotations; cell 0 is captured as the lower
    //   or upper middle value when its rank span covers that sorted position.
    //   Finish: form the chosen statistic and load the output register as soon
    //   as it is free.
    // ------------------------------------------------------------------------

    localparam int DEPTH = swss_pkg::WINDOW_DEPTH;
    localparam int SB    = swss_pkg::SAMPLE_BITS;
    localparam int LB    = swss_pkg::LEN_BITS;
    localparam int CB    = swss_pkg::CNT_BITS;

    swss_pkg::seq_state_t              state_reg, state_next;
    logic [CB-1:0]                     step_cnt_reg, step_cnt_next;
    logic [swss_pkg::SUM_BITS-1:0]     sum_reg, sum_next;
    logic [SB-1:0]                     min_reg, min_next;
    logic [SB-1:0]                     max_reg, max_next;
    logic [SB-1:0]                     med_lo_reg, med_lo_next;
    logic [SB-1:0]                     med_hi_reg, med_hi_next;
    logic [swss_pkg::MODE_BITS-1:0]    stat_mode_reg, stat_mode_next;
    logic [swss_pkg::CFG_DATA_BITS-1:0] window_log2_reg, window_log2_next;
    logic [SB-1:0]                     last_sample_reg, last_sample_next;
    logic                              out_valid_reg, out_valid_next;
    logic [SB-1:0]                     statistic_reg, statistic_next;

    swss_pkg::cell_ctrl_t              cell_ctrl;
    swss_pkg::cell_data_t              cell_data [DEPTH];
    logic [DEPTH-1:0]                  in_window;
    logic [DEPTH-1:0]                  is_tail;

    logic [swss_pkg::LOG2_BITS-1:0]    eff_log2;
    logic [LB-1:0]                     win_len;
    logic [LB-1:0]                     win_len_m1;
    logic [LB-1:0]                     k_lo;
    logic [LB-1:0]                     k_hi;
    logic [CB-1:0]                     last_step;
    logic [SB-1:0]                     probe;
    logic                              accept;
    logic                              load_out;
    logic [SB:0]                       med_sum;
    logic [SB-1:0]                     result;

    // Window length: two to the configured power, saturated at the store depth
    always_comb
    begin
        if (window_log2_reg > swss_pkg::DEPTH_LOG2)
        begin
            eff_log2 = swss_pkg::LOG2_BITS'(swss_pkg::DEPTH_LOG2);
        end
        else
        begin
            eff_log2 = swss_pkg::LOG2_BITS'(window_log2_reg);
        end
        win_len    = LB'(1) << eff_log2;
        win_len_m1 = win_len - LB'(1);
        k_lo       = win_len_m1 >> 1;
        k_hi       = win_len >> 1;
        last_step  = win_len_m1[CB-1:0];
    end

    // ------------------------------------------------------------------------
    // Cell row
    // ------------------------------------------------------------------------
    assign probe = cell_data[0].value;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam logic [LB-1:0] IDX = LB'(i);
        swss_pkg::cell_data_t src;

        assign in_window[i] = (IDX < win_len);
        assign is_tail[i]   = (IDX == win_len_m1);
        // The tail wraps round to cell 0; all others take their right neighbour
        assign src = is_tail[i] ? cell_data[0] : cell_data[(i + 1) % DEPTH];

        swss_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (cell_ctrl),
            .in_window    (in_window[i]),
            .is_tail      (is_tail[i]),
            .probe        (probe),
            .sample       (sample),
            .refill_value (last_sample_reg),
            .src          (src),
            .data_out     (cell_data[i])
        );
    end

    // ------------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------------
    assign in_stall  = (state_reg != swss_pkg::ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign statistic = statistic_reg;

    // Selected statistic, formed in the finishing cycle
    always_comb
    begin
        med_sum = {1'b0, med_lo_reg} + {1'b0, med_hi_reg};
        unique case (stat_mode_reg)
            swss_pkg::MODE_MEAN:   result = SB'(sum_reg >> eff_log2);
            swss_pkg::MODE_MIN:    result = min_reg;
            swss_pkg::MODE_MAX:    result = max_reg;
            swss_pkg::MODE_MEDIAN: result = med_sum[SB:1];
            default:               result = last_sample_reg;
        endcase
    end

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        step_cnt_next    = step_cnt_reg;
        sum_next         = sum_reg;
        min_next         = min_reg;
        max_next         = max_reg;
        med_lo_next      = med_lo_reg;
        med_hi_next      = med_hi_reg;
        stat_mode_next   = stat_mode_reg;
        window_log2_next = window_log2_reg;
        last_sample_next = last_sample_reg;
        statistic_next   = statistic_reg;
        load_out         = 1'b0;
        cell_ctrl.op       = swss_pkg::CELL_HOLD;
        cell_ctrl.count_en = 1'b0;

        unique case (state_reg)
            swss_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cell_ctrl.op     = swss_pkg::CELL_SHIFT;
                    last_sample_next = sample;
                    step_cnt_next    = '0;
                    state_next       = swss_pkg::ST_SCAN;
                end
            end
            swss_pkg::ST_SCAN:
            begin
                cell_ctrl.op       = swss_pkg::CELL_ROTATE;
                cell_ctrl.count_en = 1'b1;
                // Start the folds afresh on the first probe
                if (step_cnt_reg == '0)
                begin
                    sum_next = swss_pkg::SUM_BITS'(probe);
                    min_next = probe;
                    max_next = probe;
                end
                else
                begin
                    sum_next = sum_reg + swss_pkg::SUM_BITS'(probe);
                    min_next = (probe < min_reg) ? probe : min_reg;
                    max_next = (probe > max_reg) ? probe : max_reg;
                end
                if (step_cnt_reg == last_step)
                begin
                    step_cnt_next = '0;
                    state_next    = (stat_mode_reg == swss_pkg::MODE_MEDIAN) ?
                                    swss_pkg::ST_PICK : swss_pkg::ST_FIN;
                end
                else
                begin
                    step_cnt_next = step_cnt_reg + CB'(1);
                end
            end
            swss_pkg::ST_PICK:
            begin
                cell_ctrl.op = swss_pkg::CELL_ROTATE;
                // A sample whose rank span covers a middle position is that value
                if ((cell_data[0].lt <= k_lo) && (cell_data[0].le > k_lo))
                begin
                    med_lo_next = probe;
                end
                if ((cell_data[0].lt <= k_hi) && (cell_data[0].le > k_hi))
                begin
                    med_hi_next = probe;
                end
                if (step_cnt_reg == last_step)
                begin
                    step_cnt_next = '0;
                    state_next    = swss_pkg::ST_FIN;
                end
                else
                begin
                    step_cnt_next = step_cnt_reg + CB'(1);
                end
            end
            swss_pkg::ST_FIN:
            begin
                // Hold the result until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    load_out       = 1'b1;
                    statistic_next = result;
                    state_next     = swss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swss_pkg::ST_IDLE;
            end
        endcase

        // Configuration write: update the register and refill the store
        if (cfg_we)
        begin
            cell_ctrl.op       = swss_pkg::CELL_REFILL;
            cell_ctrl.count_en = 1'b0;
            unique case (cfg_index)
                swss_pkg::CFG_STAT_MODE:   stat_mode_next   = cfg_data;
                swss_pkg::CFG_WINDOW_LOG2: window_log2_next = cfg_data;
                default:                   stat_mode_next   = stat_mode_reg;
            endcase
        end

        // Drop the result once taken, set it when a new one is loaded
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state and the registers whose reset values are visible
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= swss_pkg::ST_IDLE;
            step_cnt_reg    <= '0;
            stat_mode_reg   <= swss_pkg::MODE_PASS;
            window_log2_reg <= '0;
            last_sample_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            step_cnt_reg    <= step_cnt_next;
            stat_mode_reg   <= stat_mode_next;
            window_log2_reg <= window_log2_next;
            last_sample_reg <= last_sample_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Folds and the result: payload, no reset
    always_ff @(posedge clk)
    begin
        sum_reg       <= sum_next;
        min_reg       <= min_next;
        max_reg       <= max_next;
        med_lo_reg    <= med_lo_next;
        med_hi_reg    <= med_hi_next;
        statistic_reg <= statistic_next;
    end

endmodule

`default_nettype wire

// File: rtl/swss_cell.sv
// One window cell: a stored sample and its two rank counts.
// Depends on swss_pkg for widths, the cell operation codes and the cell structs.
`default_nettype none

module swss_cell (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire swss_pkg::cell_ctrl_t                ctrl,
    input  wire logic                                in_window,
    input  wire logic                                is_tail,
    input  wire logic [swss_pkg::SAMPLE_BITS-1:0]    probe,
    input  wire logic [swss_pkg::SAMPLE_BITS-1:0]    sample,
    input  wire logic [swss_pkg::SAMPLE_BITS-1:0]    refill_value,
    input  wire swss_pkg::cell_data_t                src,
    output swss_pkg::cell_data_t                     data_out
);

    logic [swss_pkg::SAMPLE_BITS-1:0] value_reg, value_next;
    logic [swss_pkg::LEN_BITS-1:0]    lt_reg, lt_next;
    logic [swss_pkg::LEN_BITS-1:0]    le_reg, le_next;
    logic                             inc_lt, inc_le;

    // Count probes strictly below and not above the held value
    always_comb
    begin
        inc_lt = ctrl.count_en && (probe < value_reg);
        inc_le = ctrl.count_en && (probe <= value_reg);
        data_out.value = value_reg;
        data_out.lt    = lt_reg + swss_pkg::LEN_BITS'(inc_lt);
        data_out.le    = le_reg + swss_pkg::LEN_BITS'(inc_le);
    end

    always_comb
    begin
        value_next = value_reg;
        lt_next    = lt_reg;
        le_next    = le_reg;
        case (ctrl.op)
            swss_pkg::CELL_SHIFT:
            begin
                if (in_window)
                begin
                    value_next = is_tail ? sample : src.value;
                    lt_next    = '0;
                    le_next    = '0;
                end
            end
            swss_pkg::CELL_ROTATE:
            begin
                if (in_window)
                begin
                    value_next = src.value;
                    lt_next    = src.lt;
                    le_next    = src.le;
                end
            end
            swss_pkg::CELL_REFILL:
            begin
                value_next = refill_value;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
            lt_reg    <= '0;
            le_reg    <= '0;
        end
        else
        begin
            value_reg <= value_next;
            lt_reg    <= lt_next;
            le_reg    <= le_next;
        end
    end

endmodule

`default_nettype wire
